// ===== rtl/rbsi_pkg.sv =====
// Package for the ray against axis-aligned box slab test.
// Holds the payload structs, fixed widths, register indexes and distance constants.
// No dependencies.
package rbsi_pkg;

    localparam int COORD_W   = 32;
    localparam int TW        = 64;
    localparam int DIST_W    = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd5;

    // Distance cap, the two unbounded markers and the saturation limit.
    localparam logic signed [TW-1:0] T_CAP     = 64'sh4000_0000_0000_0000;
    localparam logic signed [TW-1:0] T_POS_INF = 64'sh4000_0000_0000_0001;
    localparam logic signed [TW-1:0] T_NEG_INF = -64'sh4000_0000_0000_0001;
    localparam logic signed [TW-1:0] DIST_MAX  = 64'sh0000_0000_7FFF_FFFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } rbsi_in_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] hit_distance;
    } rbsi_out_t;

    // Per-axis flags that travel alongside the dividers.
    typedef struct packed {
        logic [2:0] zero;
        logic [2:0] miss;
        logic [2:0] neg_n;
        logic [2:0] neg_f;
    } rbsi_side_t;

endpackage

// ===== rtl/rbsi_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Computes (num << FB) / den over MW + FB stages; uses no package items.
module rbsi_div #(
    parameter int MW = 33,
    parameter int FB = 16
) (
    input  logic             clk,
    input  logic             en,
    input  logic [MW-1:0]    num,
    input  logic [MW-1:0]    den,
    output logic [MW+FB-1:0] quo
);

    localparam int QW = MW + FB;

    logic [MW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [MW-1:0] den_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [MW-1:0] rem_in;
        logic [MW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [MW:0]   sh;
        logic          take;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = {num, {FB{1'b0}}};
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        // Bring down the next dividend bit and try the subtraction.
        assign sh   = {rem_in, quo_in[QW-1]};
        assign take = (sh >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (take)
                    rem_reg[s] <= MW'(sh - {1'b0, den_in});
                else
                    rem_reg[s] <= sh[MW-1:0];
                quo_reg[s] <= {quo_in[QW-2:0], take};
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// ===== rtl/ray_box_slab_intersect.sv =====
// Ray against axis-aligned box slab test, one ray per cycle when the output is taken.
// Pipeline: one input stage, 33 + FRAC_BITS divider stages, then three stages
// that bound and intersect the slabs and one output stage.
// Throughput is one transfer per cycle while results are taken; the divider pipelines set the depth.
// Reset clears the box corners to zero and empties the pipeline.
module ray_box_slab_intersect
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ray_valid,
    output logic                 ray_ready,
    input  rbsi_in_t             ray,
    output logic                 res_valid,
    input  logic                 res_ready,
    output rbsi_out_t            res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    localparam int MW = COORD_W + 1;
    localparam int QW = MW + FRAC_BITS;
    localparam int EW = (QW > TW) ? QW : TW;
    localparam int L  = QW + 5;

    logic                      en;
    logic [L-1:0]              vld_reg;
    logic signed [COORD_W-1:0] lo_reg [3];
    logic signed [COORD_W-1:0] hi_reg [3];

    // Configuration registers, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= '0;
                hi_reg[a] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MIN_X: lo_reg[0] <= cfg_data;
                CFG_MIN_Y: lo_reg[1] <= cfg_data;
                CFG_MIN_Z: lo_reg[2] <= cfg_data;
                CFG_MAX_X: hi_reg[0] <= cfg_data;
                CFG_MAX_Y: hi_reg[1] <= cfg_data;
                CFG_MAX_Z: hi_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // The whole pipeline advances unless the output register holds an untaken result.
    assign en        = !vld_reg[L-1] || res_ready;
    assign ray_ready = en;
    assign res_valid = vld_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[L-2:0], ray_valid};
    end

    // Input stage: slab face offsets, magnitudes and signs.
    logic signed [COORD_W-1:0] org [3];
    logic signed [COORD_W-1:0] dir [3];
    logic [MW-1:0]             num_next [6];
    logic [MW-1:0]             den_next [3];
    rbsi_side_t                side_next;
    logic [MW-1:0]             num_reg [6];
    logic [MW-1:0]             den_reg [3];
    rbsi_side_t                side_reg [QW+1];

    assign org[0] = ray.origin_x;
    assign org[1] = ray.origin_y;
    assign org[2] = ray.origin_z;
    assign dir[0] = ray.dir_x;
    assign dir[1] = ray.dir_y;
    assign dir[2] = ray.dir_z;

    always_comb
    begin
        logic signed [COORD_W-1:0] nb;
        logic signed [COORD_W-1:0] fb;
        logic signed [MW-1:0]      dn;
        logic signed [MW-1:0]      df;
        side_next = '0;
        for (int a = 0; a < 3; a++)
        begin
            nb = dir[a][COORD_W-1] ? hi_reg[a] : lo_reg[a];
            fb = dir[a][COORD_W-1] ? lo_reg[a] : hi_reg[a];
            dn = MW'(nb) - MW'(org[a]);
            df = MW'(fb) - MW'(org[a]);
            num_next[2*a]   = dn[MW-1] ? MW'(-dn) : MW'(dn);
            num_next[2*a+1] = df[MW-1] ? MW'(-df) : MW'(df);
            den_next[a]     = dir[a][COORD_W-1] ? MW'(-MW'(dir[a])) : MW'(dir[a]);
            side_next.zero[a]  = (dir[a] == '0);
            side_next.miss[a]  = (dir[a] == '0) &&
                                 ((org[a] < lo_reg[a]) || (org[a] > hi_reg[a]));
            side_next.neg_n[a] = dn[MW-1] ^ dir[a][COORD_W-1];
            side_next.neg_f[a] = df[MW-1] ^ dir[a][COORD_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
                num_reg[i] <= num_next[i];
            for (int a = 0; a < 3; a++)
                den_reg[a] <= den_next[a];
            side_reg[0] <= side_next;
            for (int s = 1; s <= QW; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    // Six divider pipelines: near and far for each axis.
    logic [QW-1:0] quo [6];

    for (genvar i = 0; i < 6; i++)
    begin : g_div
        rbsi_div #(
            .MW (MW),
            .FB (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[i]),
            .den (den_reg[i/2]),
            .quo (quo[i])
        );
    end

    // Capped, signed slab distances; a zero direction gives an unbounded slab.
    logic signed [TW-1:0] t_next [6];
    logic signed [TW-1:0] t_reg [6];
    logic                 fail1_reg;
    rbsi_side_t           sd;

    assign sd = side_reg[QW];

    always_comb
    begin
        logic [EW-1:0] qe;
        logic [62:0]   qs;
        logic          ng;
        for (int i = 0; i < 6; i++)
        begin
            qe = EW'(quo[i]);
            qs = (qe > EW'(T_CAP)) ? T_CAP[62:0] : qe[62:0];
            ng = (i % 2 == 0) ? sd.neg_n[i/2] : sd.neg_f[i/2];
            if (sd.zero[i/2])
                t_next[i] = (i % 2 == 0) ? T_NEG_INF : T_POS_INF;
            else if (ng)
                t_next[i] = -$signed({1'b0, qs});
            else
                t_next[i] = $signed({1'b0, qs});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
                t_reg[i] <= t_next[i];
            fail1_reg <= |sd.miss;
        end
    end

    // Intersect the x and y intervals.
    logic signed [TW-1:0] tmin2_reg, tmax2_reg, tn2_reg, tf2_reg;
    logic                 fail2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fail2_reg <= fail1_reg || (t_reg[0] > t_reg[3]) || (t_reg[2] > t_reg[1]);
            tmin2_reg <= (t_reg[2] > t_reg[0]) ? t_reg[2] : t_reg[0];
            tmax2_reg <= (t_reg[3] < t_reg[1]) ? t_reg[3] : t_reg[1];
            tn2_reg   <= t_reg[4];
            tf2_reg   <= t_reg[5];
        end
    end

    // Fold in the z interval.
    logic signed [TW-1:0] tmin3_reg, tmax3_reg;
    logic                 fail3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fail3_reg <= fail2_reg || (tmin2_reg > tf2_reg) || (tn2_reg > tmax2_reg);
            tmin3_reg <= (tn2_reg > tmin2_reg) ? tn2_reg : tmin2_reg;
            tmax3_reg <= (tf2_reg < tmax2_reg) ? tf2_reg : tmax2_reg;
        end
    end

    // Output register: use the exit distance from inside the box, then saturate.
    logic signed [TW-1:0] sel;
    rbsi_out_t            res_next;
    rbsi_out_t            res_reg;

    always_comb
    begin
        sel = tmin3_reg[TW-1] ? tmax3_reg : tmin3_reg;
        if (fail3_reg || sel[TW-1])
            res_next = '0;
        else
        begin
            res_next.hit          = 1'b1;
            res_next.hit_distance = (sel > DIST_MAX) ? DIST_MAX[DIST_W-1:0]
                                                     : sel[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== tb/tb_ray_box_slab_intersect.sv =====
// Testbench for the ray against axis-aligned box slab test.
// Depends on rbsi_pkg and ray_box_slab_intersect; holds a distance predictor and scoreboard.
`timescale 1ns / 1ps

module tb_ray_box_slab_intersect;
    import rbsi_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = FRAC + 38;
    localparam longint CYCLE_LIMIT = 400000;

    // Signed 64-bit values are wide enough for the capped distances.
    localparam longint DIST_CAP = 64'sh4000_0000_0000_0000;
    localparam longint DIST_POS_UNB = DIST_CAP + 1;
    localparam longint DIST_NEG_UNB = -DIST_CAP - 1;
    localparam longint DIST_SAT = 64'sh7FFF_FFFF;

    // Scoreboard: predicts the hit result of each ray and checks results in order.
    class slab_scoreboard;
        longint box_lo[3];
        longint box_hi[3];
        rbsi_out_t pending_hits[$];
        int mismatches;

        function new();
            for (int i = 0; i < 3; i++)
            begin
                box_lo[i] = 0;
                box_hi[i] = 0;
            end
            mismatches = 0;
        endfunction

        function void write_corner(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
            longint sv;
            sv = longint'($signed(val));
            if (idx < 3)
                box_lo[idx] = sv;
            else if (idx < 6)
                box_hi[idx - 3] = sv;
        endfunction

        // Exact quotient num * 2^FRAC / den, truncated toward zero and capped.
        function longint slab_distance(longint num, longint den);
            logic [127:0] mn, md, q;
            logic negative;
            negative = (num < 0) != (den < 0);
            mn = (num < 0) ? 128'(-num) : 128'(num);
            md = (den < 0) ? 128'(-den) : 128'(den);
            q = (mn << FRAC) / md;
            if (q > 128'(DIST_CAP))
                q = 128'(DIST_CAP);
            return negative ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function rbsi_out_t predict_hit(rbsi_in_t r);
            longint org[3], dir[3];
            longint t_near, t_far, t_entry, t_exit;
            logic clear;
            rbsi_out_t res;
            org[0] = longint'(r.origin_x);
            org[1] = longint'(r.origin_y);
            org[2] = longint'(r.origin_z);
            dir[0] = longint'(r.dir_x);
            dir[1] = longint'(r.dir_y);
            dir[2] = longint'(r.dir_z);
            clear = 1'b1;
            t_entry = 0;
            t_exit = 0;
            for (int a = 0; a < 3; a++)
            begin
                if (clear)
                begin
                    if (dir[a] == 0)
                    begin
                        if (org[a] < box_lo[a] || org[a] > box_hi[a])
                            clear = 1'b0;
                        t_near = DIST_NEG_UNB;
                        t_far = DIST_POS_UNB;
                    end
                    else if (dir[a] < 0)
                    begin
                        t_near = slab_distance(box_hi[a] - org[a], dir[a]);
                        t_far = slab_distance(box_lo[a] - org[a], dir[a]);
                    end
                    else
                    begin
                        t_near = slab_distance(box_lo[a] - org[a], dir[a]);
                        t_far = slab_distance(box_hi[a] - org[a], dir[a]);
                    end
                    if (!clear)
                        ;
                    else if (a == 0)
                    begin
                        t_entry = t_near;
                        t_exit = t_far;
                    end
                    else if (t_entry > t_far || t_near > t_exit)
                        clear = 1'b0;
                    else
                    begin
                        if (t_near > t_entry)
                            t_entry = t_near;
                        if (t_far < t_exit)
                            t_exit = t_far;
                    end
                end
            end
            if (clear && t_entry < 0)
            begin
                t_entry = t_exit;
                if (t_entry < 0)
                    clear = 1'b0;
            end
            res.hit = clear;
            res.hit_distance = clear ? DIST_W'(t_entry > DIST_SAT ? DIST_SAT : t_entry) : '0;
            return res;
        endfunction

        function void note_ray(rbsi_in_t r);
            pending_hits.push_back(predict_hit(r));
        endfunction

        function void check_result(rbsi_out_t got);
            rbsi_out_t want;
            if (pending_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: hit=%0b dist=%h", got.hit, got.hit_distance);
                return;
            end
            want = pending_hits.pop_front();
            if (got.hit !== want.hit || got.hit_distance !== want.hit_distance)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected hit=%0b dist=%h, got hit=%0b dist=%h",
                             want.hit, want.hit_distance, got.hit, got.hit_distance);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic ray_valid, ray_ready;
    rbsi_in_t ray;
    logic res_valid, res_ready;
    rbsi_out_t res;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0] cfg_data;

    slab_scoreboard board;
    longint cycle_count = 0;
    bit stall_free;

    ray_box_slab_intersect #(.FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n),
        .ray_valid(ray_valid), .ray_ready(ray_ready), .ray(ray),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: sample at the rising edge, change ready at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            board.check_result(res);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
            res_ready <= stall_free ? 1'b1 : ($urandom_range(99) >= 32);
    end

    // Watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Random coordinate: mostly modest values, sometimes any bit pattern.
    function automatic logic [COORD_W-1:0] rand_coord();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return COORD_W'($signed($urandom_range(40 << FRAC)) - (20 << FRAC));
        else if (pick < 7)
            return '0;
        else
            return $urandom;
    endfunction

    // One transfer on the configuration channel; valid stays up for a following write.
    task automatic write_corner(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_corner(idx, val);
        @(negedge clk);
    endtask

    task automatic set_box(logic [COORD_W-1:0] lx, logic [COORD_W-1:0] ly,
                           logic [COORD_W-1:0] lz, logic [COORD_W-1:0] hx,
                           logic [COORD_W-1:0] hy, logic [COORD_W-1:0] hz);
        write_corner(CFG_MIN_X, lx);
        write_corner(CFG_MIN_Y, ly);
        write_corner(CFG_MIN_Z, lz);
        write_corner(CFG_MAX_X, hx);
        write_corner(CFG_MAX_Y, hy);
        write_corner(CFG_MAX_Z, hz);
        cfg_valid <= 1'b0;
    endtask

    // One ray transfer, with a random gap ahead of it unless idling is off.
    task automatic send_ray(rbsi_in_t r);
        while (!stall_free && $urandom_range(99) < 32)
        begin
            ray_valid <= 1'b0;
            @(negedge clk);
        end
        ray_valid <= 1'b1;
        ray <= r;
        @(posedge clk);
        while (!ray_ready)
            @(posedge clk);
        board.note_ray(r);
        @(negedge clk);
    endtask

    task automatic send_coords(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy,
                               logic [COORD_W-1:0] oz, logic [COORD_W-1:0] dx,
                               logic [COORD_W-1:0] dy, logic [COORD_W-1:0] dz);
        rbsi_in_t r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        send_ray(r);
    endtask

    // Ray from a random origin, mostly aimed towards a point of the box, random scale.
    task automatic send_aimed_ray();
        logic signed [COORD_W-1:0] tgt[3], org[3], dir[3];
        for (int a = 0; a < 3; a++)
        begin
            tgt[a] = COORD_W'($signed(board.box_lo[a]) +
                     COORD_W'($urandom_range(32'h7FFF) * ((board.box_hi[a] - board.box_lo[a])
                     >>> 15)));
            org[a] = rand_coord();
            dir[a] = ($urandom_range(3) == 0) ? -(tgt[a] - org[a]) : (tgt[a] - org[a]) >>>
                     $urandom_range(4);
        end
        send_coords(org[0], org[1], org[2], dir[0], dir[1], dir[2]);
    endtask

    // Let the pipeline empty before any corner is rewritten.
    task automatic drain();
        ray_valid <= 1'b0;
        while (board.pending_hits.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    localparam logic [COORD_W-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;
    localparam logic [COORD_W-1:0] ONE = 32'h0001_0000;

    initial
    begin
        board = new();
        stall_free = 1'b0;
        rst_n = 1'b0;
        ray_valid = 1'b0;
        ray = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rays against the reset box, a point at the origin.
        send_coords(0, 0, 0, 0, 0, 0);
        send_coords(ONE, 0, 0, 0, 0, 0);
        send_coords(-ONE, 0, 0, ONE, 0, 0);
        drain();

        // Unit box: hits, misses, origin inside, zero components.
        set_box(0, 0, 0, ONE, ONE, ONE);
        send_coords(-ONE, ONE >> 1, ONE >> 1, ONE, 0, 0);
        send_coords(2 * ONE, ONE >> 1, ONE >> 1, -ONE, 0, 0);
        send_coords(ONE >> 1, ONE >> 1, ONE >> 1, 0, 0, 0);
        send_coords(ONE >> 1, ONE >> 1, ONE >> 1, ONE, ONE, -ONE);
        send_coords(-ONE, 2 * ONE, ONE >> 1, ONE, 0, 0);
        send_coords(2 * ONE, ONE >> 1, ONE >> 1, ONE, 0, 0);
        send_coords(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        send_coords(-ONE, -ONE, 4 * ONE, ONE, 3 * ONE, ONE);
        send_coords(ONE, ONE, ONE, 0, 0, 0);
        send_coords(-C_MAX, ONE >> 1, ONE >> 1, 1, 0, 0);
        send_coords(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        send_coords(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        send_coords(C_MAX, C_MIN, C_MAX, 1, 32'hFFFF_FFFF, 1);
        drain();

        // Full-range box, then an inverted box.
        set_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        send_coords(C_MIN, C_MIN, C_MIN, 1, 1, 1);
        send_coords(C_MAX, 0, C_MIN, C_MIN, 0, C_MAX);
        send_coords(0, 0, 0, 0, 0, 0);
        drain();
        set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
        send_coords(0, 0, 0, ONE, ONE, ONE);
        send_coords(0, 0, 0, 0, ONE, ONE);
        send_coords(-2 * ONE, 0, 0, ONE, 32'hFFFF_0000, ONE);
        drain();

        // Random phases with fresh boxes; one phase runs without idling.
        for (int phase = 0; phase < 6; phase++)
        begin
            logic [COORD_W-1:0] lo[3], hi[3];
            for (int a = 0; a < 3; a++)
            begin
                lo[a] = rand_coord();
                hi[a] = rand_coord();
                if ($urandom_range(4) != 0 && $signed(lo[a]) > $signed(hi[a]))
                begin
                    hi[a] = lo[a] ^ hi[a];
                    lo[a] = lo[a] ^ hi[a];
                    hi[a] = lo[a] ^ hi[a];
                end
            end
            set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
            stall_free = (phase == 3);
            for (int n = 0; n < 90; n++)
            begin
                if ($urandom_range(9) < 7)
                    send_aimed_ray();
                else
                    send_coords(rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord());
            end
            stall_free = 1'b0;
            drain();
        end

        if (board.mismatches == 0 && board.pending_hits.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
